// ----- hdl/i2a_pkg.sv -----
// Shared types and constants of the integer-to-ASCII formatter.
package i2a_pkg;

	localparam int NUM_W        = 64;
	localparam int BCD_DIGITS   = 20;
	localparam int BCD_W        = 4 * BCD_DIGITS;
	localparam int DIGITS       = 24;
	localparam int DIGIT_IW     = $clog2(DIGITS);
	localparam int CNT_W        = 7;
	localparam int DABBLE_STEPS = NUM_W / 2;
	localparam int DABBLE_CW    = $clog2(DABBLE_STEPS);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 8;

	localparam logic [1:0] RADIX_OCT = 2'd0;
	localparam logic [1:0] RADIX_DEC = 2'd1;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DABBLE,
		F_EXTRACT,
		F_PUSH
	} front_state_t;

	// One formatted number: digit values least significant first, and the
	// character positions where each region of the text ends.
	typedef struct packed {
		logic [DIGITS-1:0][3:0] digits;
		logic                   upper;
		logic [7:0]             pre0;
		logic [7:0]             pre1;
		logic [CNT_W-1:0]       b1;
		logic [CNT_W-1:0]       b2;
		logic [CNT_W-1:0]       b3;
		logic [CNT_W-1:0]       b4;
		logic [CNT_W-1:0]       total;
	} job_t;

	typedef struct packed {
		logic push;
	} qctl_t;

endpackage

// ----- hdl/i2a_front.sv -----
// Front end: accepts a number, converts it to digits and lays out the text regions.
module i2a_front #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [i2a_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [i2a_pkg::S_TUSER_W-1:0]   s_tuser,
	output i2a_pkg::qctl_t                  qctl,
	input  logic                            q_full,
	output i2a_pkg::job_t                   q_job
);
	import i2a_pkg::*;

	localparam logic [CNT_W-1:0] WIDTH_MAX = CNT_W'(MAX_WIDTH);
	localparam logic [DABBLE_CW-1:0] DABBLE_LAST = DABBLE_CW'(DABBLE_STEPS - 1);

	front_state_t state_q, state_d;

	logic [NUM_W-1:0]            in_number;
	logic [1:0]                  in_radix;
	logic                        in_upper, in_signed, in_left, in_plus, in_space, in_alt, in_zero;
	logic [CNT_W-1:0]            in_width;
	logic                        in_neg;
	logic [NUM_W-1:0]            in_mag;
	logic [7:0]                  in_pre0, in_pre1;
	logic [1:0]                  in_np;
	logic                        accept;

	logic [NUM_W-1:0]            bin_q;
	logic [BCD_W-1:0]            bcd_q;
	logic [DABBLE_CW-1:0]        cnt_q;
	logic [DIGIT_IW-1:0]         nd_q;
	logic [DIGITS-1:0][3:0]      digits_q;
	logic [7:0]                  pre0_q, pre1_q;
	logic [1:0]                  np_q;
	logic                        left_q, zero_q, upper_q, octal_q;
	logic [CNT_W-1:0]            width_q;

	logic [BCD_W-1:0]            dab_bcd;
	logic [NUM_W-1:0]            dab_bin;
	logic [3:0]                  ext_digit;
	logic [BCD_W-1:0]            ext_shift;
	logic [CNT_W-1:0]            body, pad;

	// tdata: number, left_align, force_plus, space_sign, alt_prefix, zero_fill, field_width.
	assign in_number = s_tdata[63:0];
	assign in_left   = s_tdata[64];
	assign in_plus   = s_tdata[65];
	assign in_space  = s_tdata[66];
	assign in_alt    = s_tdata[67];
	assign in_zero   = s_tdata[68];
	assign in_width  = (s_tdata[75:69] > WIDTH_MAX) ? WIDTH_MAX : s_tdata[75:69];
	// tuser: radix_select, upper_case, signed_mode.
	assign in_radix  = s_tuser[1:0];
	assign in_upper  = s_tuser[2];
	assign in_signed = s_tuser[3];

	assign in_neg = in_signed & in_number[NUM_W-1];
	assign in_mag = in_neg ? (NUM_W'(0) - in_number) : in_number;
	assign accept = s_tvalid & s_tready;

	always_comb begin
		in_pre0 = CH_SPACE;
		in_pre1 = CH_SPACE;
		in_np   = 2'd0;
		if (in_neg) begin
			in_pre0 = CH_MINUS;
			in_np   = 2'd1;
		end else if (in_plus) begin
			in_pre0 = CH_PLUS;
			in_np   = 2'd1;
		end else if (in_space) begin
			in_pre0 = CH_SPACE;
			in_np   = 2'd1;
		end else if (in_alt && (in_number != '0)) begin
			if (in_radix == RADIX_OCT) begin
				in_pre0 = CH_ZERO;
				in_np   = 2'd1;
			end else if (in_radix != RADIX_DEC) begin
				in_pre0 = CH_ZERO;
				in_pre1 = in_upper ? CH_UPPER_X : CH_LOWER_X;
				in_np   = 2'd2;
			end
		end
	end

	// Two steps of shift-and-add-3 binary to BCD conversion per cycle.
	always_comb begin
		dab_bcd = bcd_q;
		dab_bin = bin_q;
		for (int s = 0; s < 2; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (dab_bcd[4*d +: 4] >= 4'd5)
					dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + 4'd3;
			end
			dab_bcd = {dab_bcd[BCD_W-2:0], dab_bin[NUM_W-1]};
			dab_bin = {dab_bin[NUM_W-2:0], 1'b0};
		end
	end

	assign ext_digit = octal_q ? {1'b0, bcd_q[2:0]} : bcd_q[3:0];
	assign ext_shift = octal_q ? (bcd_q >> 3) : (bcd_q >> 4);

	always_comb begin
		body  = CNT_W'(np_q) + CNT_W'(nd_q);
		pad   = (width_q > body) ? (width_q - body) : '0;
		q_job.digits = digits_q;
		q_job.upper  = upper_q;
		q_job.pre0   = pre0_q;
		q_job.pre1   = pre1_q;
		q_job.b1     = (!left_q && !zero_q) ? pad : '0;
		q_job.b2     = q_job.b1 + CNT_W'(np_q);
		q_job.b3     = q_job.b2 + ((!left_q && zero_q) ? pad : '0);
		q_job.b4     = q_job.b3 + CNT_W'(nd_q);
		q_job.total  = q_job.b4 + (left_q ? pad : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		qctl.push = 1'b0;
		case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = (in_radix == RADIX_DEC) ? F_DABBLE : F_EXTRACT;
			end
			F_DABBLE: begin
				if (cnt_q == DABBLE_LAST)
					state_d = F_EXTRACT;
			end
			F_EXTRACT: begin
				if (ext_shift == '0)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) begin
					qctl.push = 1'b1;
					state_d   = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q   <= in_mag;
			bcd_q   <= (in_radix == RADIX_DEC) ? '0 : BCD_W'(in_mag);
			cnt_q   <= '0;
			nd_q    <= '0;
			pre0_q  <= in_pre0;
			pre1_q  <= in_pre1;
			np_q    <= in_np;
			left_q  <= in_left;
			zero_q  <= in_zero;
			upper_q <= in_upper;
			octal_q <= (in_radix == RADIX_OCT);
			width_q <= in_width;
		end else if (state_q == F_DABBLE) begin
			bcd_q <= dab_bcd;
			bin_q <= dab_bin;
			cnt_q <= cnt_q + 1'b1;
		end else if (state_q == F_EXTRACT) begin
			digits_q[nd_q] <= ext_digit;
			nd_q           <= nd_q + 1'b1;
			bcd_q          <= ext_shift;
		end
	end

`ifndef SYNTHESIS
	a_digits_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) |-> ((nd_q != '0) && (nd_q < DIGIT_IW'(DIGITS))))
		else $error("digit count out of range at hand-off");
`endif

endmodule

// ----- hdl/i2a_queue.sv -----
// Two-entry queue of formatted numbers between the front and back ends.
module i2a_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  i2a_pkg::qctl_t qctl,
	input  i2a_pkg::job_t  job_in,
	input  logic           pop,
	output i2a_pkg::job_t  job_out,
	output logic           full,
	output logic           empty
);
	import i2a_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign job_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qctl.push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (qctl.push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !qctl.push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (qctl.push)
			mem_q[wr_ptr_q] <= job_in;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push |-> !full)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");
`endif

endmodule

// ----- hdl/i2a_back.sv -----
// Back end: walks the text of the queued number and sends one character per transfer.
module i2a_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2a_pkg::job_t                 head,
	input  logic                          head_valid,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [i2a_pkg::M_TDATA_W-1:0] m_tdata, // char_out
	output logic                          m_tlast  // last_char
);
	import i2a_pkg::*;

	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] didx;
	logic [7:0]       ch;
	logic             last;
	logic             advance;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] alpha;
		alpha = upper ? CH_UPPER_A : CH_LOWER_A;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'b0, d};
		else
			digit_char = alpha + {4'b0, d} - 8'd10;
	endfunction

	// Digits are stored least significant first and sent most significant first.
	assign didx = head.b4 - k_q - 1'b1;

	always_comb begin
		if (k_q < head.b1)
			ch = CH_SPACE;
		else if (k_q < head.b2)
			ch = (k_q == head.b1) ? head.pre0 : head.pre1;
		else if (k_q < head.b3)
			ch = CH_ZERO;
		else if (k_q < head.b4)
			ch = digit_char(head.digits[didx[DIGIT_IW-1:0]], head.upper);
		else
			ch = CH_SPACE;
	end

	assign last    = (k_q == head.total - 1'b1);
	assign advance = head_valid && (!out_valid_q || m_tready);
	assign pop     = advance && last;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				k_q         <= last ? '0 : (k_q + 1'b1);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= ch;
			out_last_q <= last;
		end
	end

`ifndef SYNTHESIS
	a_pos_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (k_q < head.total))
		else $error("character position beyond the end of the text");
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (m_tvalid && m_tlast && (k_q == '0)))
		else $error("number retired without its last character");
`endif

endmodule

// ----- hdl/integer_to_ascii_formatter.sv -----
// Top level of the printf-style integer-to-ASCII formatter.
// Usage:
//   The slave channel takes one number per transfer with its radix, case,
//   signedness, flags and field width; the master channel returns the text
//   one ASCII character per transfer, with tlast on the final character.
//   The front end accepts a number only when it is idle. Octal and hex
//   digits are peeled off one per cycle; decimal first runs shift-and-add-3
//   BCD conversion over all 64 bits (two bits a cycle), then peels digits.
//   The front end takes no new number until the last one is in the queue,
//   and a two-entry queue lets it work ahead of the back end.
//   The back end sends one character per cycle while the receiver is ready.
//   When the receiver stalls, the output register holds its character,
//   the queue fills and the front end then waits. Reset empties the queue,
//   clears the output valid flag, the character position and the front
//   end's state; the data registers are not cleared.
module integer_to_ascii_formatter #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// number, left_align, force_plus, space_sign, alt_prefix, zero_fill, field_width
	input  logic [i2a_pkg::S_TDATA_W-1:0]   s_tdata,
	// radix_select, upper_case, signed_mode
	input  logic [i2a_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// char_out
	output logic [i2a_pkg::M_TDATA_W-1:0]   m_tdata,
	// last_char
	output logic                            m_tlast
);
	import i2a_pkg::*;

	qctl_t qctl;
	job_t  job_in, job_head;
	logic  q_full, q_empty, q_pop;

	i2a_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qctl     (qctl),
		.q_full   (q_full),
		.q_job    (job_in)
	);

	i2a_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.qctl    (qctl),
		.job_in  (job_in),
		.pop     (q_pop),
		.job_out (job_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	i2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (job_head),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
